// ----- rtl/core/wan_pkg.sv -----
package wan_pkg;

  // Table geometry
  localparam int DaysPerWeek        = 7;
  localparam int SlotsPerDayDefault = 4;

  // Field widths
  localparam int DayW    = 3;
  localparam int HourW   = 5;
  localparam int MinuteW = 6;
  localparam int IdxW    = 2;
  localparam int CfgW    = 7;
  localparam int LeadW   = 6;
  localparam int BuzzW   = 2;

  // Register reset values
  localparam logic [DaysPerWeek-1:0] DaysMaskReset = 7'd127;
  localparam logic [LeadW-1:0]       LeadReset     = 6'd10;

  // Chime hours
  localparam logic [HourW-1:0] ChimeFirstHour = 5'd6;
  localparam logic [HourW-1:0] ChimeLastHour  = 5'd23;
  localparam logic [HourW-1:0] LoudHourA      = 5'd7;
  localparam logic [HourW-1:0] LoudHourB      = 5'd12;
  localparam logic [HourW-1:0] LoudHourC      = 5'd18;
  localparam logic [6:0]       MinutesPerHour = 7'd60;

  // Command codes
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Configuration register indexes
  localparam logic CFG_DAYS_MASK = 1'b0;
  localparam logic CFG_LEAD      = 1'b1;

  // Buzzer codes
  localparam logic [BuzzW-1:0] BUZZ_OFF    = 2'd0;
  localparam logic [BuzzW-1:0] BUZZ_NORMAL = 2'd1;
  localparam logic [BuzzW-1:0] BUZZ_LOUD   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;   // transaction accepted, latch fields
    logic rd_en;  // read slot at rd_idx
    logic eval;   // registered slot data is valid, fold it in
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic day_active;  // weekday of incoming tick is enabled
    logic hit_up;      // slot under check lies in the lead window
  } dp_status_t;

endpackage

// ----- rtl/core/weekly_alarm_notifier_core.sv -----
// A write or a tick on a disabled day reports in the cycle after start.
// A tick on an enabled day scans its slots one per cycle through the registered
// slot memory read and ends early on a hit. The receiver cannot stall.
// Throughput: a new transaction is taken in the cycle that shows the result.
// Reset clears all slots to inactive, the day mask to all days and lead to 10.
// done_o is high for a single cycle; upcoming_o and buzzer_o hold to the next load.
module weekly_alarm_notifier_core #(
  parameter int SLOTS_PER_DAY = wan_pkg::SlotsPerDayDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         cmd_i,
  input  logic [wan_pkg::DayW-1:0]     weekday_i,
  input  logic [wan_pkg::HourW-1:0]    hour_i,
  input  logic [wan_pkg::MinuteW-1:0]  minute_i,
  input  logic                         chime_enable_i,
  input  logic [wan_pkg::IdxW-1:0]     slot_index_i,
  input  logic                         slot_active_i,
  input  logic [wan_pkg::HourW-1:0]    slot_hour_i,
  input  logic [wan_pkg::MinuteW-1:0]  slot_minute_i,
  input  logic                         cfg_we_i,
  input  logic                         cfg_index_i,
  input  logic [wan_pkg::CfgW-1:0]     cfg_wdata_i,
  output logic                         done_o,
  output logic                         upcoming_o,
  output logic [wan_pkg::BuzzW-1:0]    buzzer_o
);
  import wan_pkg::*;

  localparam int SlotIdxW = (SLOTS_PER_DAY > 1) ? $clog2(SLOTS_PER_DAY) : 1;

  ctrl_cmd_t             ctrl_cmd;
  dp_status_t            dp_status;
  logic [SlotIdxW-1:0]   rd_idx;

  // Scan sequencer
  wan_ctrl #(
    .SlotsPerDay (SLOTS_PER_DAY),
    .SlotIdxW    (SlotIdxW)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .cmd_in_i (cmd_i),
    .status_i (dp_status),
    .cmd_o    (ctrl_cmd),
    .rd_idx_o (rd_idx),
    .busy     (busy),
    .done_o   (done_o)
  );

  // Slot store, compare and chime logic
  wan_datapath #(
    .SlotsPerDay (SLOTS_PER_DAY),
    .SlotIdxW    (SlotIdxW)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (ctrl_cmd),
    .rd_idx_i       (rd_idx),
    .status_o       (dp_status),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_in_i       (cmd_i),
    .weekday_i      (weekday_i),
    .hour_i         (hour_i),
    .minute_i       (minute_i),
    .chime_enable_i (chime_enable_i),
    .slot_index_i   (slot_index_i),
    .slot_active_i  (slot_active_i),
    .slot_hour_i    (slot_hour_i),
    .slot_minute_i  (slot_minute_i),
    .upcoming_o     (upcoming_o),
    .buzzer_o       (buzzer_o)
  );

endmodule

// ----- rtl/core/wan_datapath.sv -----
module wan_datapath #(
  parameter int SlotsPerDay = wan_pkg::SlotsPerDayDefault,
  parameter int SlotIdxW    = 2
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  wan_pkg::ctrl_cmd_t                cmd_i,
  input  logic [SlotIdxW-1:0]               rd_idx_i,
  output wan_pkg::dp_status_t               status_o,
  input  logic                              cfg_we_i,
  input  logic                              cfg_index_i,
  input  logic [wan_pkg::CfgW-1:0]          cfg_wdata_i,
  input  logic                              cmd_in_i,
  input  logic [wan_pkg::DayW-1:0]          weekday_i,
  input  logic [wan_pkg::HourW-1:0]         hour_i,
  input  logic [wan_pkg::MinuteW-1:0]       minute_i,
  input  logic                              chime_enable_i,
  input  logic [wan_pkg::IdxW-1:0]          slot_index_i,
  input  logic                              slot_active_i,
  input  logic [wan_pkg::HourW-1:0]         slot_hour_i,
  input  logic [wan_pkg::MinuteW-1:0]       slot_minute_i,
  output logic                              upcoming_o,
  output logic [wan_pkg::BuzzW-1:0]         buzzer_o
);
  import wan_pkg::*;

  localparam int Depth = DaysPerWeek * SlotsPerDay;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  // Configuration registers
  logic [DaysPerWeek-1:0] days_mask_q;
  logic [LeadW-1:0]       lead_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      days_mask_q <= DaysMaskReset;
      lead_q      <= LeadReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DAYS_MASK: days_mask_q <= cfg_wdata_i[DaysPerWeek-1:0];
        CFG_LEAD:      lead_q      <= cfg_wdata_i[LeadW-1:0];
        default:       lead_q      <= lead_q;
      endcase
    end
  end

  // Day enable lookup, weekday seven reads as inactive
  logic [7:0] day_vec;
  logic       hit_up;
  assign day_vec  = {1'b0, days_mask_q};
  assign status_o = '{day_active: day_vec[weekday_i], hit_up: hit_up};

  // Latched tick fields
  logic [DayW-1:0]    day_q;
  logic [HourW-1:0]   hour_q;
  logic [MinuteW-1:0] minute_q;
  logic               chime_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      day_q    <= weekday_i;
      hour_q   <= hour_i;
      minute_q <= minute_i;
      chime_q  <= chime_enable_i & (cmd_in_i == CMD_TICK);
    end
  end

  // Slot store: active bits in flops cleared at reset, time fields in memory
  logic [Depth-1:0]               active_q;
  logic [HourW+MinuteW-1:0]       mem_q [Depth];
  logic                           wr_en;
  logic [AddrW-1:0]               waddr;
  logic [AddrW-1:0]               raddr;
  logic                           rd_act_q;
  logic [HourW-1:0]               rd_hour_q;
  logic [MinuteW-1:0]             rd_min_q;

  assign wr_en = cmd_i.load && (cmd_in_i == CMD_WRITE) &&
                 (32'(weekday_i) < DaysPerWeek) && (32'(slot_index_i) < SlotsPerDay);
  assign waddr = AddrW'(32'(weekday_i) * SlotsPerDay + 32'(slot_index_i));
  assign raddr = AddrW'(32'(day_q) * SlotsPerDay + 32'(rd_idx_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (wr_en) begin
      active_q[waddr] <= slot_active_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[waddr] <= {slot_hour_i, slot_minute_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_act_q              <= active_q[raddr];
      {rd_hour_q, rd_min_q} <= mem_q[raddr];
    end
  end

  // Window compare on the slot under check
  logic [6:0] now_plus_lead;
  logic [6:0] slot_plus_hour;
  logic       same_hour;
  logic       next_hour;
  logic       hit_sig;

  assign now_plus_lead  = 7'(minute_q) + 7'(lead_q);
  assign slot_plus_hour = 7'(rd_min_q) + MinutesPerHour;
  assign same_hour      = (hour_q == rd_hour_q);
  assign next_hour      = ((6'(hour_q) + 6'd1) == 6'(rd_hour_q));
  assign hit_sig        = rd_act_q && same_hour && (minute_q == rd_min_q);

  always_comb begin
    hit_up = 1'b0;
    if (rd_act_q) begin
      if (same_hour) begin
        hit_up = (7'(rd_min_q) <= now_plus_lead) && (rd_min_q >= minute_q);
      end else if (next_hour) begin
        hit_up = (slot_plus_hour < now_plus_lead);
      end
    end
  end

  // Result accumulation
  logic upcoming_q;
  logic signal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upcoming_q <= 1'b0;
      signal_q   <= 1'b0;
    end else if (cmd_i.load) begin
      upcoming_q <= 1'b0;
      signal_q   <= 1'b0;
    end else if (cmd_i.eval) begin
      upcoming_q <= upcoming_q | hit_up;
      signal_q   <= signal_q | hit_sig;
    end
  end

  // Buzzer decode
  always_comb begin
    buzzer_o = BUZZ_OFF;
    if (chime_q && (hour_q >= ChimeFirstHour) && (hour_q <= ChimeLastHour) &&
        (signal_q || (minute_q == '0))) begin
      if (signal_q || (hour_q inside {LoudHourA, LoudHourB, LoudHourC})) begin
        buzzer_o = BUZZ_LOUD;
      end else begin
        buzzer_o = BUZZ_NORMAL;
      end
    end
  end

  assign upcoming_o = upcoming_q;

endmodule

// ----- rtl/core/wan_ctrl.sv -----
module wan_ctrl #(
  parameter int SlotsPerDay = wan_pkg::SlotsPerDayDefault,
  parameter int SlotIdxW    = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  input  logic                  cmd_in_i,
  input  wan_pkg::dp_status_t   status_i,
  output wan_pkg::ctrl_cmd_t    cmd_o,
  output logic [SlotIdxW-1:0]   rd_idx_o,
  output logic                  busy,
  output logic                  done_o
);
  import wan_pkg::*;

  state_e                state_q, state_d;
  logic [SlotIdxW-1:0]   idx_q;
  logic                  issued_all_q;
  logic                  chk_valid_q;
  logic                  chk_last_q;
  logic                  accept;
  logic                  idx_last;

  assign busy     = (state_q == ST_SCAN);
  assign done_o   = (state_q == ST_DONE);
  assign accept   = start && !busy;
  assign idx_last = (idx_q == SlotIdxW'(SlotsPerDay - 1));
  assign rd_idx_o = idx_q;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o.load  = 1'b0;
    cmd_o.rd_en = 1'b0;
    cmd_o.eval  = 1'b0;
    case (state_q)
      ST_IDLE, ST_DONE: begin
        cmd_o.load = accept;
        if (accept) begin
          if (cmd_in_i == CMD_TICK && status_i.day_active) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_DONE;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd_o.rd_en = !issued_all_q;
        cmd_o.eval  = chk_valid_q;
        if (chk_valid_q && (status_i.hit_up || chk_last_q)) begin
          state_d = ST_DONE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Slot counter and read pipeline tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      issued_all_q <= 1'b0;
      chk_valid_q  <= 1'b0;
      chk_last_q   <= 1'b0;
    end else if (cmd_o.load) begin
      idx_q        <= '0;
      issued_all_q <= 1'b0;
      chk_valid_q  <= 1'b0;
      chk_last_q   <= 1'b0;
    end else if (state_q == ST_SCAN) begin
      chk_valid_q <= cmd_o.rd_en;
      chk_last_q  <= idx_last;
      if (cmd_o.rd_en) begin
        if (idx_last) begin
          issued_all_q <= 1'b1;
        end else begin
          idx_q <= idx_q + SlotIdxW'(1);
        end
      end
    end
  end

  // A write transaction always reports in the next cycle
  a_write_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (cmd_in_i == CMD_WRITE) |=> done_o)
    else $error("write transaction did not complete in one cycle");

  // A slot is only checked after it was read
  a_chk_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) && chk_valid_q |-> $past(cmd_o.rd_en))
    else $error("slot checked without a read");

  // Every scan starts at slot zero
  a_scan_from_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_SCAN) ##1 (state_q == ST_SCAN) |-> (idx_q == '0) && !chk_valid_q)
    else $error("scan did not start at slot zero");

  // Once all reads are issued the counter sits on the last slot
  a_last_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) && issued_all_q |-> idx_last)
    else $error("slot counter moved past the last slot");

endmodule
